[rtl/assert_macros.svh]
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked property check, disabled while reset is asserted.
`define ASSERT_PROP(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Condition that must hold whenever the enable term is true.
`define ASSERT_WHEN(lbl, clk, rst_n, en, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (en) |-> (cond)) else $error(msg);

`endif

[rtl/rfd_pkg.sv]
package rfd_pkg;

    // Frame format.
    localparam logic [7:0] START_BYTE   = 8'h01;
    localparam int         BUF_DEPTH    = 32;
    localparam int         ADDR_W       = $clog2(BUF_DEPTH);
    localparam int         LEN_W        = 6;
    localparam int         HDR_CNT_W    = 3;

    // Header byte positions after the start byte.
    localparam logic [HDR_CNT_W-1:0] HDR_ID_HI   = 3'd0;
    localparam logic [HDR_CNT_W-1:0] HDR_ID_LO   = 3'd1;
    localparam logic [HDR_CNT_W-1:0] HDR_LEN_HI  = 3'd2;
    localparam logic [HDR_CNT_W-1:0] HDR_LEN_LO  = 3'd3;
    localparam logic [HDR_CNT_W-1:0] HDR_TYPE_HI = 3'd4;
    localparam logic [HDR_CNT_W-1:0] HDR_TYPE_LO = 3'd5;
    localparam logic [HDR_CNT_W-1:0] HDR_LAST    = 3'd6;

    // Reset value of the length limit register.
    localparam logic [LEN_W-1:0] MAX_LEN_RESET = 6'd20;

    // Output beat packing.
    localparam int OUT_DATA_W = 56;
    localparam int OUT_USER_W = 2;

    // Frame handed from the parser to the emitter once the checksum beat is registered.
    typedef struct packed {
        logic             start;
        logic [15:0]      frame_id;
        logic [15:0]      msg_type;
        logic [LEN_W-1:0] len;
        logic             ok;
    } frame_info_t;

endpackage

[rtl/rfd_payload_ram.sv]
module rfd_payload_ram #(
    parameter int DEPTH = 32,
    parameter int WIDTH = 8
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    // One write port and one registered read port.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

[rtl/rfd_parser.sv]
module rfd_parser
    import rfd_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  logic [7:0]        in_byte,
    input  logic [LEN_W-1:0]  max_length,
    input  logic              emit_busy,
    output logic              wr_en,
    output logic [ADDR_W-1:0] wr_addr,
    output logic [7:0]        wr_data,
    output frame_info_t       info
);

    typedef enum logic [1:0] {P_HUNT, P_HEADER, P_PAYLOAD, P_CHECK} pstate_t;

    pstate_t                state_reg;
    logic [HDR_CNT_W-1:0]   hdr_cnt_reg;
    logic [15:0]            id_reg;
    logic [15:0]            len_reg;
    logic [15:0]            type_reg;
    logic [LEN_W-1:0]       pay_cnt_reg;
    logic [7:0]             xor_reg;
    logic                   start_reg;
    logic                   ok_reg;
    logic                   accept;
    logic                   len_ok;
    logic [LEN_W-1:0]       pay_cnt_next;

    // Input is held off while a frame is being emitted.
    assign in_ready = !(emit_busy || start_reg);
    assign accept   = in_valid && in_ready;

    assign len_ok = (len_reg <= {{(16-LEN_W){1'b0}}, max_length})
                 && (len_reg <= 16'(BUF_DEPTH));
    assign pay_cnt_next = pay_cnt_reg + 1'b1;

    // Payload bytes go straight into the buffer.
    assign wr_en   = accept && (state_reg == P_PAYLOAD);
    assign wr_addr = pay_cnt_reg[ADDR_W-1:0];
    assign wr_data = in_byte;

    assign info.start    = start_reg;
    assign info.frame_id = id_reg;
    assign info.msg_type = type_reg;
    assign info.len      = len_reg[LEN_W-1:0];
    assign info.ok       = ok_reg;

    // Frame state machine.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= P_HUNT;
            hdr_cnt_reg <= '0;
            id_reg      <= '0;
            len_reg     <= '0;
            type_reg    <= '0;
            pay_cnt_reg <= '0;
            xor_reg     <= '0;
            start_reg   <= 1'b0;
            ok_reg      <= 1'b0;
        end
        else
        begin
            // One-cycle pulse to the emitter after the checksum beat.
            start_reg <= accept && (state_reg == P_CHECK);
            if (accept)
            begin
                case (state_reg)
                    P_HUNT:
                    begin
                        if (in_byte == START_BYTE)
                        begin
                            state_reg   <= P_HEADER;
                            hdr_cnt_reg <= '0;
                            pay_cnt_reg <= '0;
                            xor_reg     <= '0;
                        end
                    end
                    P_HEADER:
                    begin
                        case (hdr_cnt_reg)
                            HDR_ID_HI:   id_reg[15:8]   <= in_byte;
                            HDR_ID_LO:   id_reg[7:0]    <= in_byte;
                            HDR_LEN_HI:  len_reg[15:8]  <= in_byte;
                            HDR_LEN_LO:  len_reg[7:0]   <= in_byte;
                            HDR_TYPE_HI: type_reg[15:8] <= in_byte;
                            HDR_TYPE_LO: type_reg[7:0]  <= in_byte;
                            default:     ;
                        endcase
                        // The last header byte is ignored; the length decides what follows.
                        if (hdr_cnt_reg == HDR_LAST)
                        begin
                            hdr_cnt_reg <= '0;
                            if (!len_ok)
                            begin
                                state_reg <= P_HUNT;
                            end
                            else if (len_reg == 16'd0)
                            begin
                                state_reg <= P_CHECK;
                            end
                            else
                            begin
                                state_reg <= P_PAYLOAD;
                            end
                        end
                        else
                        begin
                            hdr_cnt_reg <= hdr_cnt_reg + 1'b1;
                        end
                    end
                    P_PAYLOAD:
                    begin
                        xor_reg     <= xor_reg ^ in_byte;
                        pay_cnt_reg <= pay_cnt_next;
                        if ({{(16-LEN_W){1'b0}}, pay_cnt_next} >= len_reg)
                        begin
                            state_reg <= P_CHECK;
                        end
                    end
                    P_CHECK:
                    begin
                        // Checksum beat: compare and hand the frame to the emitter.
                        ok_reg      <= (in_byte == ~xor_reg);
                        state_reg   <= P_HUNT;
                        pay_cnt_reg <= '0;
                        xor_reg     <= '0;
                    end
                    default:
                    begin
                        state_reg <= P_HUNT;
                    end
                endcase
            end
        end
    end

endmodule

[rtl/rfd_emitter.sv]
module rfd_emitter
    import rfd_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  frame_info_t       info,
    output logic              busy,
    output logic              rd_en,
    output logic [ADDR_W-1:0] rd_addr,
    input  logic [7:0]        rd_data,
    output logic              out_valid,
    input  logic              out_ready,
    output logic [15:0]       frame_id,
    output logic [15:0]       msg_type,
    output logic [LEN_W-1:0]  payload_length,
    output logic [ADDR_W-1:0] byte_index,
    output logic [7:0]        payload_byte,
    output logic              has_byte,
    output logic              checksum_ok,
    output logic              last
);

    typedef enum logic [1:0] {E_IDLE, E_READ, E_LOAD, E_HOLD} estate_t;

    estate_t           state_reg;
    logic [ADDR_W-1:0] idx_reg;
    logic [15:0]       id_reg;
    logic [15:0]       type_reg;
    logic [LEN_W-1:0]  len_reg;
    logic              ok_reg;
    logic              out_valid_reg;
    logic [7:0]        byte_reg;
    logic              has_reg;
    logic              last_reg;
    logic              is_last;

    assign busy    = (state_reg != E_IDLE);
    assign rd_en   = (state_reg == E_READ);
    assign rd_addr = idx_reg;

    // Final beat of the frame: the only beat of an empty frame.
    assign is_last = (len_reg == '0)
                  || (({{(LEN_W-ADDR_W){1'b0}}, idx_reg} + 1'b1) == len_reg);

    assign out_valid      = out_valid_reg;
    assign frame_id       = id_reg;
    assign msg_type       = type_reg;
    assign payload_length = len_reg;
    assign byte_index     = idx_reg;
    assign payload_byte   = byte_reg;
    assign has_byte       = has_reg;
    assign checksum_ok    = ok_reg;
    assign last           = last_reg;

    // Read sequencer: one buffer read per output beat.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= E_IDLE;
            idx_reg       <= '0;
            id_reg        <= '0;
            type_reg      <= '0;
            len_reg       <= '0;
            ok_reg        <= 1'b0;
            out_valid_reg <= 1'b0;
            byte_reg      <= '0;
            has_reg       <= 1'b0;
            last_reg      <= 1'b0;
        end
        else
        begin
            case (state_reg)
                E_IDLE:
                begin
                    if (info.start)
                    begin
                        id_reg    <= info.frame_id;
                        type_reg  <= info.msg_type;
                        len_reg   <= info.len;
                        ok_reg    <= info.ok;
                        idx_reg   <= '0;
                        state_reg <= E_READ;
                    end
                end
                E_READ:
                begin
                    state_reg <= E_LOAD;
                end
                E_LOAD:
                begin
                    // An empty frame never wrote the buffer, so its byte is forced to zero.
                    has_reg       <= (len_reg != '0);
                    byte_reg      <= (len_reg != '0) ? rd_data : 8'd0;
                    last_reg      <= is_last;
                    out_valid_reg <= 1'b1;
                    state_reg     <= E_HOLD;
                end
                E_HOLD:
                begin
                    if (out_ready)
                    begin
                        out_valid_reg <= 1'b0;
                        if (last_reg)
                        begin
                            state_reg <= E_IDLE;
                        end
                        else
                        begin
                            idx_reg   <= idx_reg + 1'b1;
                            state_reg <= E_READ;
                        end
                    end
                end
                default:
                begin
                    state_reg <= E_IDLE;
                end
            endcase
        end
    end

endmodule

[rtl/radar_frame_deframer_unit.sv]
// Serial frame deframer. Each input beat carries one received byte. The block hunts for
// the start byte 0x01, takes seven header bytes (big-endian id, length and type, the
// seventh byte unused), buffers the payload and checks the trailing checksum byte against
// the inverted XOR of the payload. Frames longer than max_length (or 32) are dropped
// without output. After the checksum beat the block emits one output beat per payload byte,
// or a single beat with has_byte low for an empty frame. Rate: while a frame is being
// parsed one input beat is taken per cycle; after the checksum beat input stalls while
// the frame is emitted: each output beat needs a read of the payload RAM, the registered
// read data and a load of the output register, and holds until the sink is ready.
// max_length may be written at any time the block is idle; it resets to 20.
module radar_frame_deframer_unit
    import rfd_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    // Configuration: max_length.
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [LEN_W-1:0]      cfg_data,
    // Input stream.
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    input  logic [7:0]            s_axis_tdata,   // [7:0] rx_byte
    // Output stream.
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    // [15:0] frame_id, [31:16] msg_type, [37:32] payload_length, [42:38] byte_index,
    // [50:43] payload_byte, [55:51] zero
    output logic [OUT_DATA_W-1:0] m_axis_tdata,
    output logic [OUT_USER_W-1:0] m_axis_tuser,   // [0] has_byte, [1] checksum_ok
    output logic                  m_axis_tlast
);

    logic [LEN_W-1:0]  max_length_reg;
    logic              emit_busy;
    frame_info_t       info;
    logic              wr_en;
    logic [ADDR_W-1:0] wr_addr;
    logic [7:0]        wr_data;
    logic              rd_en;
    logic [ADDR_W-1:0] rd_addr;
    logic [7:0]        rd_data;
    logic [15:0]       frame_id;
    logic [15:0]       msg_type;
    logic [LEN_W-1:0]  payload_length;
    logic [ADDR_W-1:0] byte_index;
    logic [7:0]        payload_byte;
    logic              has_byte;
    logic              checksum_ok;

    // Length limit register; writes are always taken.
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_length_reg <= MAX_LEN_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            max_length_reg <= cfg_data;
        end
    end

    rfd_parser u_parser (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (s_axis_tvalid),
        .in_ready   (s_axis_tready),
        .in_byte    (s_axis_tdata),
        .max_length (max_length_reg),
        .emit_busy  (emit_busy),
        .wr_en      (wr_en),
        .wr_addr    (wr_addr),
        .wr_data    (wr_data),
        .info       (info)
    );

    rfd_payload_ram #(
        .DEPTH (BUF_DEPTH),
        .WIDTH (8)
    ) u_ram (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    rfd_emitter u_emitter (
        .clk            (clk),
        .rst_n          (rst_n),
        .info           (info),
        .busy           (emit_busy),
        .rd_en          (rd_en),
        .rd_addr        (rd_addr),
        .rd_data        (rd_data),
        .out_valid      (m_axis_tvalid),
        .out_ready      (m_axis_tready),
        .frame_id       (frame_id),
        .msg_type       (msg_type),
        .payload_length (payload_length),
        .byte_index     (byte_index),
        .payload_byte   (payload_byte),
        .has_byte       (has_byte),
        .checksum_ok    (checksum_ok),
        .last           (m_axis_tlast)
    );

    // Output beat packing.
    assign m_axis_tdata = {5'd0, payload_byte, byte_index, payload_length, msg_type, frame_id};
    assign m_axis_tuser = {checksum_ok, has_byte};

endmodule

[rtl/rfd_checker.sv]
`include "assert_macros.svh"

module rfd_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        s_axis_tready,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [55:0] m_axis_tdata,
    input logic [1:0]  m_axis_tuser,
    input logic        m_axis_tlast
);

    // A stalled output beat keeps its contents.
    `ASSERT_PROP(a_out_hold, clk, rst_n, m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser) && $stable(m_axis_tlast), "output beat changed while stalled")

    // Input is not taken while a frame is being emitted.
    `ASSERT_WHEN(a_no_input_in_burst, clk, rst_n, m_axis_tvalid, !s_axis_tready, "input ready during emission")

    // An empty frame beat is the last one and carries a zero byte.
    `ASSERT_WHEN(a_empty_frame, clk, rst_n, m_axis_tvalid && !m_axis_tuser[0], m_axis_tlast && (m_axis_tdata[50:43] == 8'd0) && (m_axis_tdata[42:38] == 5'd0) && (m_axis_tdata[37:32] == 6'd0), "bad empty frame beat")

    // The last data beat sits at the final payload position.
    `ASSERT_WHEN(a_last_index, clk, rst_n, m_axis_tvalid && m_axis_tuser[0] && m_axis_tlast, ({1'b0, m_axis_tdata[42:38]} + 6'd1) == m_axis_tdata[37:32], "last beat index mismatch")

endmodule

bind radar_frame_deframer_unit rfd_checker u_rfd_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
);

[sim/radar_frame_deframer_unit_tb.sv]
module radar_frame_deframer_unit_tb;

    timeunit 1ns;
    timeprecision 1ps;

    import rfd_pkg::*;

    // Longest correct stretch without any beat is the sink hold-off followed
    // by the emission of a full frame; the limit is several times that.
    localparam int STALL_LIMIT   = 3000;
    // Long enough for the emission of a full 32-byte frame.
    localparam int DRAIN_CYCLES  = 100;
    localparam int SINK_HOLD_LEN = 400;
    localparam int PHASE_ITEMS   = 24;

    typedef enum logic [1:0] {
        PH_HUNT,
        PH_HEADER,
        PH_PAYLOAD,
        PH_CHECK
    } parse_phase_t;

    // One output beat as the deframer should present it.
    typedef struct packed {
        logic [15:0]       frame_id;
        logic [15:0]       msg_type;
        logic [LEN_W-1:0]  payload_length;
        logic [ADDR_W-1:0] byte_index;
        logic [7:0]        payload_byte;
        logic              has_byte;
        logic              checksum_ok;
        logic              last;
    } frame_beat_t;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [LEN_W-1:0]      cfg_data = '0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    logic [7:0]            s_axis_tdata = '0;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    logic [OUT_DATA_W-1:0] m_axis_tdata;
    logic [OUT_USER_W-1:0] m_axis_tuser;
    logic                  m_axis_tlast;

    // Parser state mirrored by the predictor.
    parse_phase_t          phase = PH_HUNT;
    logic [HDR_CNT_W-1:0]  hdr_cnt = '0;
    logic [15:0]           hdr_id = '0;
    logic [15:0]           hdr_len = '0;
    logic [15:0]           hdr_type = '0;
    logic [LEN_W-1:0]      pay_cnt = '0;
    logic [7:0]            xor_acc = '0;
    logic [7:0]            pay_store [BUF_DEPTH];
    logic [LEN_W-1:0]      max_len = MAX_LEN_RESET;

    frame_beat_t           beats_due [$];
    int                    mismatches = 0;
    int                    used_items = 0;
    int                    src_idle_pct = 13;
    int                    sink_idle_pct = 13;
    int                    sink_hold = 0;
    int                    quiet_cycles = 0;

    radar_frame_deframer_unit DUT (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_data      (cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    always #2 clk = ~clk;

    // Predict the output beats caused by one accepted input byte.
    function automatic void deframe_byte(input logic [7:0] b);
        frame_beat_t beat;
        logic        sum_ok;
        if (phase != PH_HUNT || b == START_BYTE)
            used_items++;
        case (phase)
            PH_HUNT:
            begin
                if (b == START_BYTE)
                begin
                    phase   = PH_HEADER;
                    hdr_cnt = '0;
                    pay_cnt = '0;
                    xor_acc = '0;
                end
            end
            PH_HEADER:
            begin
                case (hdr_cnt)
                    HDR_ID_HI:   hdr_id   = {b, 8'h00};
                    HDR_ID_LO:   hdr_id   = {hdr_id[15:8], b};
                    HDR_LEN_HI:  hdr_len  = {b, 8'h00};
                    HDR_LEN_LO:  hdr_len  = {hdr_len[15:8], b};
                    HDR_TYPE_HI: hdr_type = {b, 8'h00};
                    HDR_TYPE_LO: hdr_type = {hdr_type[15:8], b};
                    default:     ;
                endcase
                if (hdr_cnt == HDR_LAST)
                begin
                    hdr_cnt = '0;
                    if (hdr_len > max_len || hdr_len > BUF_DEPTH)
                        phase = PH_HUNT;
                    else if (hdr_len == 0)
                        phase = PH_CHECK;
                    else
                        phase = PH_PAYLOAD;
                end
                else
                    hdr_cnt++;
            end
            PH_PAYLOAD:
            begin
                if (pay_cnt < BUF_DEPTH)
                    pay_store[pay_cnt[ADDR_W-1:0]] = b;
                xor_acc ^= b;
                pay_cnt++;
                if (pay_cnt >= hdr_len)
                    phase = PH_CHECK;
            end
            default:
            begin
                // Checksum byte: the whole frame comes out now.
                sum_ok = (b == ~xor_acc);
                beat.frame_id    = hdr_id;
                beat.msg_type    = hdr_type;
                beat.checksum_ok = sum_ok;
                if (hdr_len == 0)
                begin
                    beat.payload_length = '0;
                    beat.byte_index     = '0;
                    beat.payload_byte   = '0;
                    beat.has_byte       = 1'b0;
                    beat.last           = 1'b1;
                    beats_due.push_back(beat);
                end
                else
                begin
                    for (int k = 0; k < hdr_len && k < BUF_DEPTH; k++)
                    begin
                        beat.payload_length = hdr_len[LEN_W-1:0];
                        beat.byte_index     = k[ADDR_W-1:0];
                        beat.payload_byte   = pay_store[k];
                        beat.has_byte       = 1'b1;
                        beat.last           = (k + 1 == hdr_len);
                        beats_due.push_back(beat);
                    end
                end
                phase   = PH_HUNT;
                pay_cnt = '0;
                xor_acc = '0;
            end
        endcase
    endfunction

    // Offer one byte with random gaps, then wait for it to be taken.
    task automatic send_byte(input logic [7:0] b);
        @(negedge clk);
        while ($urandom_range(99) < src_idle_pct)
        begin
            s_axis_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= b;
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        deframe_byte(b);
    endtask

    // Send a frame from the hunting state; a dropped frame stops after its header.
    task automatic send_frame(input logic [15:0] fid, input logic [15:0] flen,
                              input logic [15:0] ftype, input bit sum_good);
        logic [7:0] xsum;
        logic [7:0] b;
        send_byte(START_BYTE);
        send_byte(fid[15:8]);
        send_byte(fid[7:0]);
        send_byte(flen[15:8]);
        send_byte(flen[7:0]);
        send_byte(ftype[15:8]);
        send_byte(ftype[7:0]);
        send_byte(8'($urandom));
        if (phase != PH_HUNT)
        begin
            xsum = 8'h00;
            while (phase == PH_PAYLOAD)
            begin
                b = 8'($urandom);
                xsum ^= b;
                send_byte(b);
            end
            if (sum_good)
                send_byte(~xsum);
            else
                send_byte(~xsum ^ 8'($urandom_range(255, 1)));
        end
    endtask

    // Push random bytes until the parser is back to hunting.
    task automatic flush_to_hunt();
        while (phase != PH_HUNT)
            send_byte(8'($urandom));
    endtask

    // Stop offering input and wait until every predicted beat has arrived.
    task automatic wait_for_results();
        @(negedge clk);
        s_axis_tvalid <= 1'b0;
        while (beats_due.size() != 0)
            @(posedge clk);
    endtask

    // Write the length limit once the block has gone quiet.
    task automatic write_max_length(input logic [LEN_W-1:0] v);
        flush_to_hunt();
        wait_for_results();
        repeat (DRAIN_CYCLES) @(posedge clk);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_data  <= v;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        max_len = v;
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    // Reset limit, noise while hunting, empty frame, bad checksum, one-over drop.
    task automatic test_directed_frames();
        send_byte(8'h00);
        send_byte(8'hFF);
        send_frame(16'hFFFF, 16'd0, 16'h0000, 1'b1);
        send_frame(16'h0000, 16'd1, 16'hFFFF, 1'b0);
        send_frame(16'h1234, 16'(MAX_LEN_RESET + 1), 16'h8001, 1'b1);
    endtask

    // Limit register at its extremes, including the 32-byte buffer cap.
    task automatic test_length_limits();
        write_max_length(6'd0);
        send_frame(16'h0F0F, 16'd0, 16'hF0F0, 1'b1);
        send_frame(16'h0F0F, 16'd1, 16'hF0F0, 1'b1);
        write_max_length(6'd32);
        send_frame(16'h5A5A, 16'd32, 16'hA5A5, 1'b1);
        send_frame(16'h5A5A, 16'd33, 16'hA5A5, 1'b1);
        send_frame(16'h5A5A, 16'h0100, 16'hA5A5, 1'b1);
        write_max_length(6'd63);
        send_frame(16'hC3C3, 16'd32, 16'h3C3C, 1'b0);
        send_frame(16'hC3C3, 16'd33, 16'h3C3C, 1'b1);
    endtask

    // Sink holds off while frames keep arriving, then the source pauses.
    task automatic test_output_backpressure();
        write_max_length(6'd32);
        sink_hold = SINK_HOLD_LEN;
        send_frame(16'($urandom), 16'd32, 16'($urandom), 1'b1);
        send_frame(16'($urandom), 16'd3, 16'($urandom), 1'b1);
        wait_for_results();
        send_frame(16'($urandom), 16'd5, 16'($urandom), 1'b1);
    endtask

    // Mostly well-formed frames, some oversized ones and some stray bytes.
    task automatic test_random_traffic();
        int          lim;
        int          stop_at;
        int          pick;
        int          n_noise;
        logic [15:0] flen;
        for (int p = 0; p < 4; p++)
        begin
            case (p)
                0:       lim = $urandom_range(31, 2);
                1:       lim = 32;
                2:       lim = 1;
                default: lim = $urandom_range(31, 2);
            endcase
            write_max_length(6'(lim));
            // The last phase runs both sides without gaps.
            if (p == 3)
            begin
                src_idle_pct  = 0;
                sink_idle_pct = 0;
            end
            stop_at = used_items + PHASE_ITEMS;
            while (used_items < stop_at)
            begin
                pick = $urandom_range(99);
                if (pick < 75)
                begin
                    if ($urandom_range(99) < 15)
                        flen = 16'($urandom_range(lim, 0));
                    else
                        flen = 16'($urandom_range(lim < 8 ? lim : 8, 0));
                    send_frame(16'($urandom), flen, 16'($urandom),
                               $urandom_range(99) < 85);
                end
                else if (pick < 88)
                begin
                    if ($urandom_range(1) == 0)
                        flen = 16'(lim + 1);
                    else
                        flen = 16'($urandom_range(65535, lim + 1));
                    send_frame(16'($urandom), flen, 16'($urandom), 1'b1);
                end
                else
                begin
                    n_noise = $urandom_range(5, 1);
                    repeat (n_noise) send_byte(8'($urandom));
                    flush_to_hunt();
                end
            end
            src_idle_pct  = 13;
            sink_idle_pct = 13;
        end
    endtask

    // Sink side: random ready, or a counted hold-off when one is requested.
    always @(negedge clk)
    begin
        if (sink_hold > 0)
        begin
            m_axis_tready <= 1'b0;
            sink_hold = sink_hold - 1;
        end
        else
            m_axis_tready <= ($urandom_range(99) >= sink_idle_pct);
    end

    task automatic compare_field(input string name, input logic [15:0] want,
                                 input logic [15:0] got);
        if (got !== want)
        begin
            $display("%0t ns: %s expected 0x%0h, got 0x%0h", $time, name, want, got);
            mismatches++;
        end
    endtask

    // Compare every output beat with the oldest predicted one.
    always @(posedge clk)
    begin : check_output
        frame_beat_t got;
        frame_beat_t want;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            got.frame_id       = m_axis_tdata[15:0];
            got.msg_type       = m_axis_tdata[31:16];
            got.payload_length = m_axis_tdata[37:32];
            got.byte_index     = m_axis_tdata[42:38];
            got.payload_byte   = m_axis_tdata[50:43];
            got.has_byte       = m_axis_tuser[0];
            got.checksum_ok    = m_axis_tuser[1];
            got.last           = m_axis_tlast;
            if (beats_due.size() == 0)
            begin
                $display("%0t ns: unexpected output beat, expected none, got %p", $time, got);
                mismatches++;
            end
            else
            begin
                want = beats_due.pop_front();
                compare_field("frame_id", want.frame_id, got.frame_id);
                compare_field("msg_type", want.msg_type, got.msg_type);
                compare_field("payload_length", 16'(want.payload_length),
                              16'(got.payload_length));
                compare_field("byte_index", 16'(want.byte_index), 16'(got.byte_index));
                compare_field("payload_byte", 16'(want.payload_byte), 16'(got.payload_byte));
                compare_field("has_byte", 16'(want.has_byte), 16'(got.has_byte));
                compare_field("checksum_ok", 16'(want.checksum_ok), 16'(got.checksum_ok));
                compare_field("last", 16'(want.last), 16'(got.last));
                compare_field("tdata padding", 16'h0000, 16'(m_axis_tdata[55:51]));
            end
        end
    end

    // Watchdog: end the run if no beat moves on any channel for too long.
    always @(posedge clk)
    begin
        if (!rst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)
            || (cfg_valid && cfg_ready))
            quiet_cycles = 0;
        else
        begin
            quiet_cycles = quiet_cycles + 1;
            if (quiet_cycles >= STALL_LIMIT)
            begin
                $display("%0t ns: no beat for %0d cycles, %0d beats still expected",
                         $time, STALL_LIMIT, beats_due.size());
                $display("== FAIL ==");
                $finish;
            end
        end
    end

    // Test sequence.
    initial
    begin
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        test_directed_frames();
        test_length_limits();
        test_output_backpressure();
        test_random_traffic();

        flush_to_hunt();
        wait_for_results();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatches == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
